// File: rtl/q8bq_pkg.sv
// Package: shared constants, request types and unit interfaces of the q8 block quantizer.
`timescale 1ns / 1ps
package q8bq_pkg;

  localparam int BLOCK_LEN = 32;
  localparam int IDX_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int CNT_W     = $clog2(BLOCK_LEN + 1);
  localparam int RAM_AW    = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** RAM_AW;

  localparam logic [31:0] D_FALLBACK = 32'h2EDB_E6FF;  // 1e-10 single
  localparam logic [31:0] F_POS_INF  = 32'h7F80_0000;
  localparam logic [15:0] HALF_INF   = 16'h7C00;
  localparam logic [7:0]  QMAX       = 8'd127;

  typedef struct packed {
    logic [31:0] elem_bits;
    logic        row_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       block_done;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [30:0]      amax;
  } blk_t;

  typedef struct packed {
    logic [23:0]        num;
    logic [23:0]        den;
    logic signed [9:0]  shift;
  } div_req_t;

  typedef struct packed {
    logic [32:0] quot;
    logic        sat;
  } div_rsp_t;

endpackage

// File: rtl/q8_block_quantizer.sv
// Top level: q8 block quantizer with decoupled element front end and block back end.
`timescale 1ns / 1ps
//
//  channel | direction | handshake             | request payload
//  --------+-----------+-----------------------+----------------------------------
//  in      | into      | in_valid_i/in_stall_o | in_i: elem_bits, row_end
//  out     | out of    | out_valid_o/out_stall_i | out_o: out_byte, block_done
//
//  An element request is taken while one of the two element banks
//  is free; the input stalls only while both banks hold closed, unfinished blocks.
//  A closed block leaves as 2 + BLOCK_LEN byte requests. The scale comes from a
//  normalize loop and a shift-and-add reduction by 127; each held element is then
//  divided by the bit-serial divider that produces one quotient bit per cycle,
//  unless it or the scale is infinite or NaN; empty slots emit a zero code.
//  Reset clears all control state; the element RAM is not cleared, only written
//  slots are read. Output stalls hold the output register and back up the back end.
//
module q8_block_quantizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  q8bq_pkg::in_t     in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output q8bq_pkg::out_t    out_o
);
  import q8bq_pkg::*;

  // front end to block queue
  logic              push;
  blk_t              push_blk;
  logic              wr_en;
  logic [RAM_AW-1:0] wr_addr;
  logic [31:0]       wr_data;

  // queue to back end
  blk_t              fifo_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              pop;

  // blocks closed but not yet fully emitted; each owns one bank
  logic [1:0]        busy_q;
  logic              bank_free;

  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [31:0]       rd_data;

  logic              div_start, div_done;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  q8bq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i         (in_i),
    .banks_full_i (busy_q == 2'd2),
    .push_o       (push),
    .blk_o        (push_blk),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  q8bq_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // hold closed block descriptors until the back end takes them
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      busy_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
      busy_q  <= busy_q + {1'b0, push} - {1'b0, bank_free};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= push_blk;
  end

  q8bq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .rsp_o   (div_rsp)
  );

  q8bq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_valid_i (count_q != 2'd0),
    .blk_i       (fifo_q[rd_ptr_q]),
    .blk_pop_o   (pop),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .div_start_o (div_start),
    .div_req_o   (div_req),
    .div_done_i  (div_done),
    .div_rsp_i   (div_rsp),
    .bank_free_o (bank_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

// File: rtl/q8bq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module q8bq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/q8bq_front.sv
// Front end: accept elements, store them in the current bank, track the block maximum.
`timescale 1ns / 1ps
module q8bq_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  q8bq_pkg::in_t                  in_i,
  input  logic                           banks_full_i,
  output logic                           push_o,
  output q8bq_pkg::blk_t                 blk_o,
  output logic                           wr_en_o,
  output logic [q8bq_pkg::RAM_AW-1:0]    wr_addr_o,
  output logic [31:0]                    wr_data_o
);
  import q8bq_pkg::*;

  logic [CNT_W-1:0] fill_q, fill_d, fill_n;
  logic [30:0]      amax_q, amax_d, amax_n;
  logic             bank_q, bank_d;
  logic             accept, close;
  logic [30:0]      mag;

  assign in_stall_o = banks_full_i;
  assign accept     = in_valid_i & ~banks_full_i;
  assign mag        = in_i.elem_bits[30:0];
  assign fill_n     = fill_q + CNT_W'(1);
  assign close      = in_i.row_end | (fill_n == CNT_W'(BLOCK_LEN));
  // NaN never enters the maximum
  assign amax_n     = ((mag <= F_POS_INF[30:0]) && (mag > amax_q)) ? mag : amax_q;

  assign wr_en_o   = accept;
  assign wr_addr_o = {bank_q, fill_q[IDX_W-1:0]};
  assign wr_data_o = in_i.elem_bits;
  assign push_o    = accept & close;
  assign blk_o     = '{n: fill_n, amax: amax_n};

  always_comb begin
    fill_d = fill_q;
    amax_d = amax_q;
    bank_d = bank_q;
    if (accept) begin
      if (close) begin
        fill_d = '0;
        amax_d = '0;
        bank_d = ~bank_q;
      end else begin
        fill_d = fill_n;
        amax_d = amax_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      amax_q <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      amax_q <= amax_d;
      bank_q <= bank_d;
    end
  end

endmodule

// File: rtl/q8bq_div.sv
// Bit-serial restoring divider: floor(num * 2^shift / den), saturating at 2^33.
`timescale 1ns / 1ps
module q8bq_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  q8bq_pkg::div_req_t  req_i,
  output logic                done_o,
  output q8bq_pkg::div_rsp_t  rsp_o
);
  import q8bq_pkg::*;

  logic               run_q, done_q;
  logic [6:0]         i_q;
  logic [23:0]        r_q, num_q, den_q;
  logic [32:0]        q_q;
  logic               sat_q;
  logic signed [9:0]  s_q;

  logic signed [10:0] top, idx;
  logic               nbit, ge, sat_hit, finish;
  logic [24:0]        rr, rdiff;

  assign top  = 11'(req_i.shift) + 11'sd23;
  assign idx  = $signed({4'b0000, i_q}) - 11'(s_q);
  assign nbit = (idx >= 11'sd0 && idx <= 11'sd23) ? num_q[idx[4:0]] : 1'b0;
  assign rr   = {r_q, nbit};
  assign rdiff = rr - {1'b0, den_q};
  assign ge   = rr >= {1'b0, den_q};
  // a quotient bit at weight 2^33 or above means the result saturates
  assign sat_hit = ge && (i_q >= 7'd33);
  assign finish  = sat_hit || (i_q == 7'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (req_i.num == 24'd0 || top < 11'sd0 || req_i.shift >= 10'sd57) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
        end
      end else if (run_q && finish) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      s_q   <= req_i.shift;
      i_q   <= top[6:0];
      r_q   <= '0;
      q_q   <= '0;
      sat_q <= (req_i.num != 24'd0) && (req_i.shift >= 10'sd57);
    end else if (run_q) begin
      r_q   <= ge ? rdiff[23:0] : rr[23:0];
      q_q   <= {q_q[31:0], ge};
      sat_q <= sat_hit;
      i_q   <= i_q - 7'd1;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = '{quot: q_q, sat: sat_q};

endmodule

// File: rtl/q8bq_back.sv
// Back end: compute the block scale, then emit the half scale and one code per slot.
`timescale 1ns / 1ps
module q8bq_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         blk_valid_i,
  input  q8bq_pkg::blk_t               blk_i,
  output logic                         blk_pop_o,
  output logic                         rd_en_o,
  output logic [q8bq_pkg::RAM_AW-1:0]  rd_addr_o,
  input  logic [31:0]                  rd_data_i,
  output logic                         div_start_o,
  output q8bq_pkg::div_req_t           div_req_o,
  input  logic                         div_done_i,
  input  q8bq_pkg::div_rsp_t           div_rsp_i,
  output logic                         bank_free_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output q8bq_pkg::out_t               out_o
);
  import q8bq_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_NORM   = 11'b000_0000_0010,
    ST_SWAIT  = 11'b000_0000_0100,
    ST_SRND   = 11'b000_0000_1000,
    ST_HCALC  = 11'b000_0001_0000,
    ST_HLO    = 11'b000_0010_0000,
    ST_HHI    = 11'b000_0100_0000,
    ST_ERD    = 11'b000_1000_0000,
    ST_ESTART = 11'b001_0000_0000,
    ST_EWAIT  = 11'b010_0000_0000,
    ST_EOUT   = 11'b100_0000_0000
  } state_e;

  function automatic logic [15:0] to_half(input logic [31:0] f);
    logic [7:0]        e;
    logic [22:0]       m;
    logic signed [9:0] ex;
    logic [23:0]       mm, hm, rem, half;
    logic [4:0]        sh;
    logic [15:0]       res;
    e    = f[30:23];
    m    = f[22:0];
    ex   = $signed({2'b00, e}) - 10'sd112;
    mm   = {1'b1, m};
    sh   = 5'd0;
    hm   = '0;
    rem  = '0;
    half = '0;
    res  = '0;
    if (e == 8'hFF || ex >= 10'sd31) begin
      res = HALF_INF;
    end else if (ex <= 10'sd0) begin
      if (ex >= -10'sd10) begin
        sh   = 5'(10'sd14 - ex);
        hm   = mm >> sh;
        rem  = mm & ((24'd1 << sh) - 24'd1);
        half = 24'd1 << (sh - 5'd1);
        if (rem > half || (rem == half && hm[0])) hm = hm + 24'd1;
        res  = hm[15:0];
      end
    end else begin
      hm  = {9'd0, ex[4:0], m[22:13]};
      rem = {11'd0, m[12:0]};
      if (rem > 24'h1000 || (rem == 24'h1000 && hm[0])) hm = hm + 24'd1;
      res = hm[15:0];
    end
    return res;
  endfunction

  // round-half-away of the correctly rounded quotient, from the fixed-point
  // quotient floor(|x/d| * 2^26): round up once the fraction reaches one half
  // less half an ulp of the integer part's binade
  function automatic logic [7:0] quant_code(input logic [32:0] quot, input logic sat,
                                            input logic neg);
    logic [6:0]  k;
    logic [25:0] frac, thr;
    logic [3:0]  sh;
    logic [7:0]  mag;
    k    = quot[32:26];
    frac = quot[25:0];
    sh   = 4'd0;
    for (int b = 0; b < 7; b++) begin
      if (k[b]) sh = 4'(b + 2);
    end
    thr = 26'h200_0000 - (26'd1 << sh);
    mag = {1'b0, k} + {7'd0, (frac >= thr)};
    if (sat || mag > QMAX) mag = QMAX;
    return neg ? (~mag + 8'd1) : mag;
  endfunction

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [23:0]       ma_q, ma_d;
  logic signed [9:0] ea_q, ea_d;
  logic              azero_q, azero_d, ainf_q, ainf_d;
  logic [32:0]       sx_q, sx_d;
  logic [26:0]       sq_q, sq_d;
  logic [31:0]       dbits_q, dbits_d;
  logic [15:0]       hs_q, hs_d;
  logic [IDX_W-1:0]  j_q, j_d;
  logic              bank_q, bank_d;
  logic              sign_q, sign_d;
  logic [7:0]        code_q, code_d;
  logic              out_valid_q, out_valid_d;
  out_t              out_q, out_d;

  logic              can_load, last;
  logic [7:0]        be_e;
  logic [22:0]       be_m;

  // scale rounding
  logic signed [10:0] be, be_m1, bexp, rtmp;
  logic               normal, qtop;
  logic [4:0]         rsh;
  logic [26:0]        q27, kept, rshifted, lowmask;
  logic               rbit, sticky, rnd;
  logic [31:0]        base, rbits;

  // element classification
  logic [7:0]  xe, de, xeff, deff;
  logic [22:0] xm;
  logic        xnan, xinf, dinf;

  assign can_load = ~out_valid_q | ~out_stall_i;
  assign last     = (j_q == IDX_W'(BLOCK_LEN - 1));
  assign be_e     = blk_i.amax[30:23];
  assign be_m     = blk_i.amax[22:0];

  // the quotient spans two binades; a set bit 26 moves the point up by one
  assign q27    = sq_q;
  assign qtop   = q27[26];
  assign be     = 11'(ea_q) + 11'sd143;
  assign be_m1  = be - 11'sd1;
  assign bexp   = qtop ? be : be_m1;
  assign normal = be >= 11'sd1;
  assign rtmp   = 11'sd3 - be;
  assign rsh    = normal ? (qtop ? 5'd3 : 5'd2) :
                  ((rtmp > 11'sd28) ? 5'd28 : rtmp[4:0]);
  assign kept     = q27 >> rsh;
  assign rshifted = q27 >> (rsh - 5'd1);
  assign rbit     = rshifted[0];
  assign lowmask  = (27'd1 << (rsh - 5'd1)) - 27'd1;
  assign sticky   = (|(q27 & lowmask)) | (sx_q != 33'd0);
  assign rnd      = rbit & (sticky | kept[0]);
  assign base     = normal ? {1'b0, bexp[7:0], 23'd0} : 32'd0;
  assign rbits    = base + {5'd0, kept} + {31'd0, rnd};

  assign xe   = rd_data_i[30:23];
  assign xm   = rd_data_i[22:0];
  assign de   = dbits_q[30:23];
  assign xnan = (xe == 8'hFF) && (xm != 23'd0);
  assign xinf = (xe == 8'hFF) && (xm == 23'd0);
  assign dinf = (de == 8'hFF);
  assign xeff = (xe == 8'd0) ? 8'd1 : xe;
  assign deff = (de == 8'd0) ? 8'd1 : de;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    ma_d        = ma_q;
    ea_d        = ea_q;
    azero_d     = azero_q;
    ainf_d      = ainf_q;
    sx_d        = sx_q;
    sq_d        = sq_q;
    dbits_d     = dbits_q;
    hs_d        = hs_q;
    j_d         = j_q;
    bank_d      = bank_q;
    sign_d      = sign_q;
    code_d      = code_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    blk_pop_o   = 1'b0;
    rd_en_o     = 1'b0;
    div_start_o = 1'b0;
    div_req_o   = '0;
    bank_free_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (blk_valid_i) begin
          blk_pop_o = 1'b1;
          n_d       = blk_i.n;
          azero_d   = (blk_i.amax == 31'd0);
          ainf_d    = (be_e == 8'hFF);
          ma_d      = {(be_e != 8'd0), be_m};
          ea_d      = $signed({2'b00, ((be_e == 8'd0) ? 8'd1 : be_e)}) - 10'sd150;
          state_d   = ST_NORM;
        end
      end
      ST_NORM: begin
        if (azero_q) begin
          dbits_d = D_FALLBACK;
          state_d = ST_HCALC;
        end else if (ainf_q) begin
          dbits_d = F_POS_INF;
          state_d = ST_HCALC;
        end else if (ma_q[23]) begin
          sx_d    = {ma_q, 9'd0};
          sq_d    = '0;
          state_d = ST_SWAIT;
        end else begin
          ma_d = {ma_q[22:0], 1'b0};
          ea_d = ea_q - 10'sd1;
        end
      end
      // divide by 127: 128a + b = 127a + (a + b), fold a into the quotient
      // until the rest fits seven bits, then one final compare and subtract
      ST_SWAIT: begin
        if (sx_q >= 33'd128) begin
          sq_d = sq_q + {1'b0, sx_q[32:7]};
          sx_d = {7'd0, sx_q[32:7]} + {26'd0, sx_q[6:0]};
        end else begin
          if (sx_q >= 33'd127) begin
            sq_d = sq_q + 27'd1;
            sx_d = sx_q - 33'd127;
          end
          state_d = ST_SRND;
        end
      end
      ST_SRND: begin
        dbits_d = (rbits == 32'd0) ? D_FALLBACK : rbits;
        state_d = ST_HCALC;
      end
      ST_HCALC: begin
        hs_d    = to_half(dbits_q);
        state_d = ST_HLO;
      end
      ST_HLO: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: hs_q[7:0], block_done: 1'b0};
          state_d     = ST_HHI;
        end
      end
      ST_HHI: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: hs_q[15:8], block_done: 1'b0};
          j_d         = '0;
          state_d     = ST_ERD;
        end
      end
      ST_ERD: begin
        if (CNT_W'(j_q) < n_q) begin
          rd_en_o = 1'b1;
          state_d = ST_ESTART;
        end else begin
          code_d  = 8'd0;
          state_d = ST_EOUT;
        end
      end
      ST_ESTART: begin
        sign_d = rd_data_i[31];
        if (xnan || dinf) begin
          code_d  = 8'd0;
          state_d = ST_EOUT;
        end else if (xinf) begin
          code_d  = rd_data_i[31] ? (~QMAX + 8'd1) : QMAX;
          state_d = ST_EOUT;
        end else begin
          div_start_o = 1'b1;
          div_req_o   = '{num:   {(xe != 8'd0), xm},
                          den:   {(de != 8'd0), dbits_q[22:0]},
                          shift: $signed({2'b00, xeff}) - $signed({2'b00, deff}) + 10'sd26};
          state_d     = ST_EWAIT;
        end
      end
      ST_EWAIT: begin
        if (div_done_i) begin
          code_d  = quant_code(div_rsp_i.quot, div_rsp_i.sat, sign_q);
          state_d = ST_EOUT;
        end
      end
      ST_EOUT: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: code_q, block_done: last};
          if (last) begin
            bank_free_o = 1'b1;
            bank_d      = ~bank_q;
            state_d     = ST_IDLE;
          end else begin
            j_d     = j_q + IDX_W'(1);
            state_d = ST_ERD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rd_addr_o   = {bank_q, j_q};
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bank_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bank_q      <= bank_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    ma_q    <= ma_d;
    ea_q    <= ea_d;
    azero_q <= azero_d;
    ainf_q  <= ainf_d;
    sx_q    <= sx_d;
    sq_q    <= sq_d;
    dbits_q <= dbits_d;
    hs_q    <= hs_d;
    j_q     <= j_d;
    sign_q  <= sign_d;
    code_q  <= code_d;
    out_q   <= out_d;
  end

endmodule

// File: tb/tb.sv
// Testbench for the q8 block quantizer: directed and random element streams checked byte by byte.
`timescale 1ns / 1ps
module tb;
  import q8bq_pkg::*;

  localparam int WATCHDOG_CYCLES = 6000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  out_t out_o;

  q8_block_quantizer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // shadow of the block's element buffer
  logic [31:0] blk_elems [BLOCK_LEN];
  int unsigned blk_fill = 0;
  logic [30:0] blk_amax = '0;
  out_t pending_bytes[$];

  int unsigned n_fail = 0, n_elems = 0, n_bytes = 0, n_blocks = 0;
  bit idle_on = 1'b1;
  int unsigned rx_hold = 0;
  int unsigned idle_cnt = 0;

  // exact single-to-double widening
  function automatic real widen(logic [31:0] f);
    logic [7:0] e;
    real r;
    e = f[30:23];
    if (e == 8'hFF)
      return $bitstoreal({f[31], 11'h7FF, f[22:0], 29'b0});
    if (e == 8'h00)
      r = real'(f[22:0]) * (2.0 ** (-149));
    else
      r = $bitstoreal({1'b0, 11'(int'(e) - 127 + 1023), f[22:0], 29'b0});
    return f[31] ? -r : r;
  endfunction

  // double to single, round to nearest even, subnormals kept
  function automatic logic [31:0] narrow(real r);
    logic [63:0] b, mant, q, rem, half;
    logic [31:0] sgn;
    int es, sh;
    b = $realtobits(r);
    sgn = {b[63], 31'b0};
    if (b[62:52] == 11'h7FF)
      return sgn | 32'h7F80_0000 | ((b[51:0] != 0) ? 32'h0040_0000 : 32'h0);
    if (b[62:0] == 0) return sgn;
    es = int'(b[62:52]) - 1023 + 127;
    if (es >= 255) return sgn | F_POS_INF;
    mant = {11'b0, 1'b1, b[51:0]};
    sh = 29 + ((es <= 0) ? (1 - es) : 0);
    if (sh >= 60) return sgn;
    q = mant >> sh;
    rem = mant & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    if (es <= 0) return sgn | q[31:0];
    return sgn | (32'(es - 1) << 23) + q[31:0];
  endfunction

  function automatic logic [15:0] half_of(logic [31:0] f);
    logic [15:0] sgn;
    int ex, sh;
    logic [31:0] m, hm, rem, hf;
    sgn = {f[31], 15'b0};
    m = {9'b0, f[22:0]};
    ex = int'(f[30:23]) - 127 + 15;
    if (f[30:23] == 8'hFF) return sgn | HALF_INF | ((m != 0) ? 16'h0200 : 16'h0);
    if (ex >= 31) return sgn | HALF_INF;
    if (ex <= 0) begin
      if (ex < -10) return sgn;
      m |= 32'h0080_0000;
      sh = 14 - ex;
      hm = m >> sh;
      rem = m & ((32'd1 << sh) - 1);
      hf = 32'd1 << (sh - 1);
      if (rem > hf || (rem == hf && hm[0])) hm++;
      return sgn | hm[15:0];
    end
    hm = (32'(ex) << 10) | (m >> 13);
    rem = m & 32'h1FFF;
    if (rem > 32'h1000 || (rem == 32'h1000 && hm[0])) hm++;
    return sgn | hm[15:0];
  endfunction

  function automatic logic [7:0] code_of(logic [31:0] x, logic [31:0] d);
    logic [31:0] tb_bits;
    real t, a;
    int q;
    bit neg;
    tb_bits = narrow(widen(x) / widen(d));
    if (tb_bits[30:23] == 8'hFF && tb_bits[22:0] != 0) return 8'h00;
    t = widen(tb_bits);
    if (t >= 127.0) return 8'd127;
    if (t <= -127.0) return 8'h81;
    neg = t < 0.0;
    a = neg ? -t : t;
    q = int'($floor(a));
    if (a - real'(q) >= 0.5) q++;
    if (q > 127) q = 127;
    if (neg) q = -q;
    return 8'(q);
  endfunction

  // advance the shadow by one element; emit the block's bytes when it closes
  task automatic quantize_element(input in_t req);
    logic [31:0] d;
    logic [15:0] hs;
    if (blk_fill >= BLOCK_LEN) blk_fill = 0;
    blk_elems[blk_fill] = req.elem_bits;
    blk_fill++;
    if (req.elem_bits[30:0] <= 31'h7F80_0000 && req.elem_bits[30:0] > blk_amax)
      blk_amax = req.elem_bits[30:0];
    if (!req.row_end && blk_fill < BLOCK_LEN) return;
    d = narrow(widen({1'b0, blk_amax}) / 127.0);
    if (d[30:0] == 0) d = D_FALLBACK;
    hs = half_of(d);
    pending_bytes.push_back('{out_byte: hs[7:0], block_done: 1'b0});
    pending_bytes.push_back('{out_byte: hs[15:8], block_done: 1'b0});
    for (int j = 0; j < BLOCK_LEN; j++)
      pending_bytes.push_back('{out_byte: (j < blk_fill) ? code_of(blk_elems[j], d) : 8'h00,
                                block_done: (j == BLOCK_LEN - 1)});
    blk_fill = 0;
    blk_amax = '0;
    n_blocks++;
  endtask

  // send one element request, with an optional random gap before it
  task automatic send_elem(input logic [31:0] bits, input logic last);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    repeat (gap) @(negedge clk_i);
    in_valid_i = 1'b1;
    in_i = '{elem_bits: bits, row_end: last};
    do @(posedge clk_i); while (in_stall_o);
    quantize_element(in_i);
    n_elems++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic logic [31:0] rand_elem();
    logic [31:0] v;
    int unsigned k;
    k = $urandom_range(0, 99);
    v = $urandom();
    if (k < 70) v[30:23] = 8'($urandom_range(110, 140));
    else if (k < 75) v[30:0] = 31'h7F80_0000;
    else if (k < 80) v[30:23] = 8'h00;
    else if (k < 83) v[30:0] = '0;
    return v;
  endfunction

  // exercise a wide magnitude spread per block to hit saturation and tiny codes
  task automatic test_directed();
    logic [31:0] row1 [8] = '{32'h42FE_0000, 32'h4020_0000, 32'hC020_0000, 32'hBF00_0000,
                              32'h3EFF_FFFF, 32'h7FC0_0000, 32'hC2FE_0000, 32'h0000_0001};
    foreach (row1[i]) send_elem(row1[i], i == 7);
    send_elem(32'h0000_0000, 1'b0);          // all-zero block uses fallback scale
    send_elem(32'h8000_0000, 1'b1);
    send_elem(32'h7F7F_FFFF, 1'b0);          // scale overflows half range
    send_elem(32'h3F80_0000, 1'b1);
    send_elem(32'h7F80_0000, 1'b0);          // infinite elements
    send_elem(32'hFF80_0000, 1'b0);
    send_elem(32'h4000_0000, 1'b1);
    send_elem(32'h0040_0000, 1'b0);          // subnormal magnitudes
    send_elem(32'h0000_0001, 1'b1);
    send_elem(32'hFFFF_FFFF, 1'b1);          // lone NaN row
  endtask

  task automatic test_full_block();
    for (int i = 0; i < BLOCK_LEN; i++) send_elem(rand_elem(), 1'b0);
  endtask

  // hold the output long enough that both banks fill and the input stalls
  task automatic test_backpressure();
    rx_hold = 800;
    idle_on = 1'b0;
    for (int i = 0; i < 3 * BLOCK_LEN; i++) send_elem(rand_elem(), 1'b0);
    idle_on = 1'b1;
    wait (pending_bytes.size() == 0);
  endtask

  task automatic test_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_elem(rand_elem(), $urandom_range(0, 11) == 0);
    end
    send_elem(rand_elem(), 1'b1);
  endtask

  // output side: random stall per byte, plus the long hold
  int unsigned rx_gap = 0;
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_stall_i <= 1'b1;
      rx_hold <= rx_hold - 1;
    end else if (rx_gap > 0) begin
      out_stall_i <= 1'b1;
      rx_gap <= rx_gap - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_t exp_b;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_bytes++;
      rx_gap <= idle_on ? $urandom_range(0, 16) : 0;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual %h/%b",
                 $time, out_o.out_byte, out_o.block_done);
        n_fail++;
      end else begin
        exp_b = pending_bytes.pop_front();
        if (out_o.out_byte !== exp_b.out_byte) begin
          $display("%0t: out_byte mismatch, expected %h, actual %h",
                   $time, exp_b.out_byte, out_o.out_byte);
          n_fail++;
        end
        if (out_o.block_done !== exp_b.block_done) begin
          $display("%0t: block_done mismatch, expected %b, actual %b",
                   $time, exp_b.block_done, out_o.block_done);
          n_fail++;
        end
      end
    end
  end

  // watchdog: cycles with no request accepted on either side
  int unsigned quiet = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet <= 0;
    else if (pending_bytes.size() != 0 || in_valid_i) quiet <= quiet + 1;
    if (quiet >= WATCHDOG_CYCLES) begin
      $display("%0t: timeout with %0d bytes outstanding", $time, pending_bytes.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_full_block();
    test_backpressure();
    test_random(180);
    wait (pending_bytes.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("Covered %0d elements in %0d blocks, %0d bytes checked,", n_elems, n_blocks,
             n_bytes);
    $display("including specials, short rows and a long output hold.");
    if (n_fail == 0 && pending_bytes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: q8_block_quantizer.f
rtl/q8bq_pkg.sv
rtl/q8bq_ram.sv
rtl/q8bq_front.sv
rtl/q8bq_div.sv
rtl/q8bq_back.sv
rtl/q8_block_quantizer.sv
tb/tb.sv
